/* rtl/fsc_pkg.sv */
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and constants of the file scan selector: header signatures,
// wildcard characters, result causes and the token that moves along the cells.
// ----------------------------------------------------------------------------
package fsc_pkg;

   localparam int CHAR_W    = 8;
   localparam int WORD_W    = 64;
   localparam int WORD_CHRS = WORD_W / CHAR_W;
   localparam int EPOS_W    = 4;   // holds 0..8, the extension position
   localparam int CAUSE_W   = 3;

   // item kinds
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // configuration register indexes
   localparam logic [1:0] REG_LIST_VALID    = 2'd0;
   localparam logic [1:0] REG_PATTERN_COUNT = 2'd1;

   // result causes
   localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 3'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_INVALID = 3'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_OFFICE  = 3'd2;
   localparam logic [CAUSE_W-1:0] CAUSE_EXEC    = 3'd3;
   localparam logic [CAUSE_W-1:0] CAUSE_EXT     = 3'd4;

   // pattern characters with a meaning of their own
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_QUEST = 8'h3F;
   localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

   // compound document signatures, first and second header word
   localparam logic [31:0] SIG_STD_FIRST  = 32'hE011CFD0;
   localparam logic [31:0] SIG_STD_SECOND = 32'hE11AB1A1;
   localparam logic [31:0] SIG_B1_FIRST   = 32'hE011CFD0;
   localparam logic [31:0] SIG_B1_SECOND  = 32'h0DCF110E;
   localparam logic [31:0] SIG_B2_FIRST   = 32'h0DFC110E;
   localparam logic [31:0] SIG_B2_SECOND  = 32'hE011CFD0;

   // executable marks in the first two header bytes
   localparam logic [15:0] MARK_MZ = 16'h5A4D;
   localparam logic [15:0] MARK_ZM = 16'h4D5A;
   localparam logic [15:0] MARK_NE = 16'h454E;
   localparam logic [15:0] MARK_LE = 16'h454C;
   localparam logic [15:0] MARK_PE = 16'h4550;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } ctl_state_type;

   typedef enum logic [1:0] {
      TK_RUN,
      TK_MATCH,
      TK_FAIL
   } tk_state_type;

   // one pattern on its way through the matcher row
   typedef struct packed {
      logic               valid;
      logic               last;
      tk_state_type       state;
      logic               skip;
      logic [EPOS_W-1:0]  epos;
      logic [WORD_W-1:0]  pattern;
   } token_type;

   function automatic logic [WORD_W-1:0] upper_word(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] r;
      logic [CHAR_W-1:0] c;
      r = '0;
      for (int i = 0; i < WORD_CHRS; i++) begin
         c = w[i*CHAR_W +: CHAR_W];
         if (c >= CH_LC_A && c <= CH_LC_Z) begin
            c = c - CASE_OFS;
         end
         r[i*CHAR_W +: CHAR_W] = c;
      end
      return r;
   endfunction

endpackage

/* rtl/fsc_ram.sv */
// ----------------------------------------------------------------------------
// fsc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fsc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/fsc_cell.sv */
// ----------------------------------------------------------------------------
// fsc_cell
// One step of the wildcard matcher: works off the pattern character at the
// head of the token against the extension and hands the token on.
// ----------------------------------------------------------------------------
module fsc_cell #(
   parameter int MAX_CHARS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fsc_pkg::token_type           tok_in,
   input  logic [fsc_pkg::WORD_W-1:0]   ext_text,
   input  logic [fsc_pkg::EPOS_W-1:0]   ext_len,
   output fsc_pkg::token_type           tok_out
);

   fsc_pkg::token_type                tok_in_w;
   fsc_pkg::token_type                tok_ff;
   logic [fsc_pkg::CHAR_W-1:0]        cur_ch;
   logic [fsc_pkg::CHAR_W-1:0]        nxt_ch;
   logic                              lit_ok;
   logic                              star_found;
   logic [fsc_pkg::EPOS_W-1:0]        star_pos;
   logic                              ext_left;

   assign cur_ch   = tok_in.pattern[0 +: fsc_pkg::CHAR_W];
   assign nxt_ch   = tok_in.pattern[fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W];
   assign ext_left = (tok_in.epos < ext_len);

   // literal compare at the current position, first hit of the star search
   always_comb begin
      lit_ok     = 1'b0;
      star_found = 1'b0;
      star_pos   = '0;
      for (int j = 0; j < MAX_CHARS; j++) begin
         if (fsc_pkg::EPOS_W'(j) == tok_in.epos && fsc_pkg::EPOS_W'(j) < ext_len &&
             ext_text[j*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W] == cur_ch) begin
            lit_ok = 1'b1;
         end
      end
      for (int j = MAX_CHARS - 1; j >= 0; j--) begin
         if (fsc_pkg::EPOS_W'(j) >= tok_in.epos && fsc_pkg::EPOS_W'(j) < ext_len &&
             ext_text[j*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W] == nxt_ch) begin
            star_found = 1'b1;
            star_pos   = fsc_pkg::EPOS_W'(j);
         end
      end
   end

   always_comb begin
      tok_in_w         = tok_in;
      tok_in_w.pattern = {{fsc_pkg::CHAR_W{1'b0}},
                          tok_in.pattern[fsc_pkg::WORD_W-1:fsc_pkg::CHAR_W]};
      if (tok_in.valid && tok_in.state == fsc_pkg::TK_RUN) begin
         if (tok_in.skip) begin
            // character already taken by the star before it
            tok_in_w.skip = 1'b0;
         end else begin
            case (cur_ch)
               fsc_pkg::CH_NUL: begin
                  tok_in_w.state = (tok_in.epos == ext_len) ? fsc_pkg::TK_MATCH
                                                            : fsc_pkg::TK_FAIL;
               end
               fsc_pkg::CH_STAR: begin
                  if (nxt_ch == fsc_pkg::CH_NUL) begin
                     tok_in_w.state = fsc_pkg::TK_MATCH;
                  end else if (star_found) begin
                     tok_in_w.epos = star_pos + fsc_pkg::EPOS_W'(1);
                     tok_in_w.skip = 1'b1;
                  end else begin
                     tok_in_w.state = fsc_pkg::TK_FAIL;
                  end
               end
               fsc_pkg::CH_QUEST: begin
                  if (ext_left) begin
                     tok_in_w.epos = tok_in.epos + fsc_pkg::EPOS_W'(1);
                  end else begin
                     tok_in_w.state = fsc_pkg::TK_FAIL;
                  end
               end
               default: begin
                  if (lit_ok) begin
                     tok_in_w.epos = tok_in.epos + fsc_pkg::EPOS_W'(1);
                  end else begin
                     tok_in_w.state = fsc_pkg::TK_FAIL;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_w.valid;
      end
      tok_ff.last    <= tok_in_w.last;
      tok_ff.state   <= tok_in_w.state;
      tok_ff.skip    <= tok_in_w.skip;
      tok_ff.epos    <= tok_in_w.epos;
      tok_ff.pattern <= tok_in_w.pattern;
   end

   assign tok_out = tok_ff;

endmodule

/* rtl/file_scan_selector.sv */
// ----------------------------------------------------------------------------
// file_scan_selector
// Decides whether a file is scanned: list state, header signatures, then the
// extension against a table of wildcard patterns, one pattern per cycle
// through a row of matcher cells.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   start, busy, req_*         beat taken when start & !busy
//  response  rsp_valid, rsp_scan/cause  one-cycle strobe, no back-pressure
//  csr       csr_we, csr_index, csr_wdata  write taken when csr_we
//
//  a load beat keeps busy low
//  a query answered without the table strobes in the cycle after it is taken
//  a table search holds busy while min(pattern_count, MAX_PATTERNS) patterns are read,
//  one table read per cycle, and then while the row of MAX_CHARS cells drains
//  reset clears the csr registers, the controller and the cell valids;
//  the pattern table is undefined until loaded
// ----------------------------------------------------------------------------
module file_scan_selector #(
   parameter int MAX_PATTERNS = 64,
   parameter int MAX_CHARS    = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [5:0]                    req_slot,
   input  logic [63:0]                   req_pattern_text,
   input  logic [63:0]                   req_ext_text,
   input  logic                          req_ext_present,
   input  logic                          req_header_ok,
   input  logic [31:0]                   req_header_low,
   input  logic [31:0]                   req_header_high,
   output logic                          rsp_valid,
   output logic                          rsp_scan,
   output logic [fsc_pkg::CAUSE_W-1:0]   rsp_cause,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [6:0]                    csr_wdata
);

   localparam int AW     = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
   localparam int CNT_W  = $clog2(MAX_PATTERNS + 1);
   localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
   localparam int EW     = fsc_pkg::EPOS_W;

   // csr registers
   logic                      list_valid_ff, list_valid_in;
   logic [6:0]                pattern_count_ff, pattern_count_in;

   fsc_pkg::ctl_state_type    state_ff, state_in;
   logic [CMP_W-1:0]          idx_ff, idx_in;
   logic [CMP_W-1:0]          num_pat;
   logic                      hit_ff, hit_in;
   logic                      rd_vld_ff, rd_last_ff;
   logic [63:0]               ext_ff, ext_in;
   logic [EW-1:0]             ext_len_ff, ext_len_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_scan_ff, rsp_scan_in;
   logic [fsc_pkg::CAUSE_W-1:0] rsp_cause_ff, rsp_cause_in;

   logic                      accept;
   logic                      load_go, query_go;
   logic                      slot_ok;
   logic                      is_office, is_exec;
   logic                      need_search;
   logic                      issue_en, issue_last;
   logic [CMP_W-1:0]          idx_next;
   logic [63:0]               ext_upper;
   logic [63:0]               ram_rdata;
   logic [63:0]               pat_cut;
   logic                      out_hit;
   logic                      out_done;
   logic [fsc_pkg::CAUSE_W-1:0] early_cause;

   fsc_pkg::token_type        tok [MAX_CHARS+1];

   // ---- csr ----
   always_comb begin
      list_valid_in    = list_valid_ff;
      pattern_count_in = pattern_count_ff;
      if (csr_we) begin
         case (csr_index)
            fsc_pkg::REG_LIST_VALID:    list_valid_in    = csr_wdata[0];
            fsc_pkg::REG_PATTERN_COUNT: pattern_count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_valid_ff    <= 1'b0;
         pattern_count_ff <= '0;
      end else begin
         list_valid_ff    <= list_valid_in;
         pattern_count_ff <= pattern_count_in;
      end
   end

   // ---- request decode ----
   assign accept   = start && !busy;
   assign load_go  = accept && (req_action == fsc_pkg::ACT_LOAD);
   assign query_go = accept && (req_action == fsc_pkg::ACT_QUERY);
   assign slot_ok  = (CMP_W'(req_slot) < CMP_W'(MAX_PATTERNS));

   assign num_pat = (CMP_W'(pattern_count_ff) > CMP_W'(MAX_PATTERNS)) ?
                    CMP_W'(MAX_PATTERNS) : CMP_W'(pattern_count_ff);

   assign is_office = req_header_ok &&
      ((req_header_low == fsc_pkg::SIG_STD_FIRST &&
        req_header_high == fsc_pkg::SIG_STD_SECOND) ||
       (req_header_low == fsc_pkg::SIG_B1_FIRST &&
        req_header_high == fsc_pkg::SIG_B1_SECOND) ||
       (req_header_low == fsc_pkg::SIG_B2_FIRST &&
        req_header_high == fsc_pkg::SIG_B2_SECOND));

   assign is_exec = req_header_ok &&
      (req_header_low[15:0] == fsc_pkg::MARK_MZ || req_header_low[15:0] == fsc_pkg::MARK_ZM ||
       req_header_low[15:0] == fsc_pkg::MARK_NE || req_header_low[15:0] == fsc_pkg::MARK_LE ||
       req_header_low[15:0] == fsc_pkg::MARK_PE);

   always_comb begin
      if (!list_valid_ff) begin
         early_cause = fsc_pkg::CAUSE_INVALID;
      end else if (is_office) begin
         early_cause = fsc_pkg::CAUSE_OFFICE;
      end else if (is_exec) begin
         early_cause = fsc_pkg::CAUSE_EXEC;
      end else begin
         early_cause = fsc_pkg::CAUSE_NONE;
      end
   end

   assign need_search = list_valid_ff && !is_office && !is_exec && req_ext_present &&
                        (num_pat != '0);

   // extension, upper-cased, and its length up to the first nul
   assign ext_upper = fsc_pkg::upper_word(req_ext_text);

   always_comb begin
      ext_len_in = EW'(MAX_CHARS);
      for (int j = MAX_CHARS - 1; j >= 0; j--) begin
         if (ext_upper[j*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W] == fsc_pkg::CH_NUL) begin
            ext_len_in = EW'(j);
         end
      end
   end

   assign ext_in = query_go ? ext_upper : ext_ff;

   always_ff @(posedge clock) begin
      if (query_go) begin
         ext_len_ff <= ext_len_in;
      end
      ext_ff <= ext_in;
   end

   // ---- controller ----
   assign idx_next   = idx_ff + CMP_W'(1);
   assign issue_last = (idx_next == num_pat);
   assign out_done   = tok[MAX_CHARS].valid && tok[MAX_CHARS].last;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fsc_pkg::ST_IDLE: begin
            if (query_go && need_search) begin
               state_in = fsc_pkg::ST_ISSUE;
            end
         end
         fsc_pkg::ST_ISSUE: begin
            if (issue_last) begin
               state_in = fsc_pkg::ST_DRAIN;
            end
         end
         fsc_pkg::ST_DRAIN: begin
            if (out_done) begin
               state_in = fsc_pkg::ST_IDLE;
            end
         end
         default: state_in = fsc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy     = (state_ff != fsc_pkg::ST_IDLE);
      issue_en = (state_ff == fsc_pkg::ST_ISSUE);
   end

   always_comb begin
      idx_in = idx_ff;
      if (query_go) begin
         idx_in = '0;
      end else if (issue_en) begin
         idx_in = idx_next;
      end
   end

   // a token leaving the row: still running means the pattern ran out
   assign out_hit = tok[MAX_CHARS].valid &&
                    (tok[MAX_CHARS].state == fsc_pkg::TK_MATCH ||
                     (tok[MAX_CHARS].state == fsc_pkg::TK_RUN &&
                      tok[MAX_CHARS].epos == ext_len_ff));

   always_comb begin
      hit_in = hit_ff;
      if (query_go) begin
         hit_in = 1'b0;
      end else if (out_hit) begin
         hit_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_scan_in  = rsp_scan_ff;
      rsp_cause_in = rsp_cause_ff;
      if (query_go && !need_search) begin
         rsp_valid_in = 1'b1;
         rsp_scan_in  = (early_cause != fsc_pkg::CAUSE_NONE);
         rsp_cause_in = early_cause;
      end else if (state_ff == fsc_pkg::ST_DRAIN && out_done) begin
         rsp_valid_in = 1'b1;
         rsp_scan_in  = hit_ff || out_hit;
         rsp_cause_in = (hit_ff || out_hit) ? fsc_pkg::CAUSE_EXT : fsc_pkg::CAUSE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= issue_en;
         hit_ff       <= hit_in;
      end
      idx_ff       <= idx_in;
      rd_last_ff   <= issue_en && issue_last;
      rsp_scan_ff  <= rsp_scan_in;
      rsp_cause_ff <= rsp_cause_in;
   end

   // ---- pattern table ----
   fsc_ram #(
      .WIDTH (64),
      .DEPTH (MAX_PATTERNS)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_go && slot_ok),
      .wr_addr (AW'(req_slot)),
      .wr_data (fsc_pkg::upper_word(req_pattern_text)),
      .rd_en   (issue_en),
      .rd_addr (AW'(idx_ff)),
      .rd_data (ram_rdata)
   );

   // characters past MAX_CHARS never reach the matcher
   always_comb begin
      pat_cut = ram_rdata;
      for (int j = MAX_CHARS; j < fsc_pkg::WORD_CHRS; j++) begin
         pat_cut[j*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W] = fsc_pkg::CH_NUL;
      end
   end

   always_comb begin
      tok[0].valid   = rd_vld_ff;
      tok[0].last    = rd_last_ff;
      tok[0].state   = fsc_pkg::TK_RUN;
      tok[0].skip    = 1'b0;
      tok[0].epos    = '0;
      tok[0].pattern = pat_cut;
   end

   // ---- matcher row ----
   for (genvar k = 0; k < MAX_CHARS; k++) begin : g_cell
      fsc_cell #(
         .MAX_CHARS (MAX_CHARS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_in   (tok[k]),
         .ext_text (ext_ff),
         .ext_len  (ext_len_ff),
         .tok_out  (tok[k+1])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_scan  = rsp_scan_ff;
   assign rsp_cause = rsp_cause_ff;

endmodule

/* rtl/fsc_checker.sv */
// ----------------------------------------------------------------------------
// fsc_checker
// Port-level checks of the file scan selector, bound to the top level.
// ----------------------------------------------------------------------------
module fsc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        req_action,
   input logic                        rsp_valid,
   input logic                        rsp_scan,
   input logic [fsc_pkg::CAUSE_W-1:0] rsp_cause
);

   // scan is set exactly when some cause was found
   a_scan_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_scan == (rsp_cause != fsc_pkg::CAUSE_NONE)))
      else $error("scan flag disagrees with cause");

   // a load beat never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == fsc_pkg::ACT_LOAD) |=> !rsp_valid)
      else $error("result after a load beat");

   // a result closes the work: block is idle when it shows
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   // reset leaves the block idle and quiet
   a_reset: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("not idle after reset");

endmodule

bind file_scan_selector fsc_checker u_fsc_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_action (req_action),
   .rsp_valid  (rsp_valid),
   .rsp_scan   (rsp_scan),
   .rsp_cause  (rsp_cause)
);

/* tb/file_scan_selector_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_scan_selector_test
// Drives load and query beats through the start/busy port and follows them
// with its own model of the pattern table, header signature checks and
// greedy wildcard matcher. Every result strobe is checked in order against
// the predicted verdict. Register settings change between phases only while
// the block is idle.
// ----------------------------------------------------------------------------
module file_scan_selector_test;

   localparam int MAX_PATTERNS  = 64;
   localparam int MAX_CHARS     = 8;
   localparam int TEXT_CHRS     = MAX_CHARS + 2;
   localparam int TEXT_W        = TEXT_CHRS * fsc_pkg::CHAR_W;
   localparam int SETTLE_CYCLES = MAX_PATTERNS + MAX_CHARS + 9;
   localparam int RUN_LIMIT     = 500000;
   localparam int PHASE_BEATS   = 160;

   typedef struct packed {
      logic                       action;
      logic [5:0]                 slot;
      logic [fsc_pkg::WORD_W-1:0] pattern_text;
      logic [fsc_pkg::WORD_W-1:0] ext_text;
      logic                       ext_present;
      logic                       header_ok;
      logic [31:0]                header_low;
      logic [31:0]                header_high;
   } file_req_type;

   typedef struct packed {
      logic                        scan;
      logic [fsc_pkg::CAUSE_W-1:0] cause;
   } verdict_type;

   logic                        clock             = 1'b0;
   logic                        reset             = 1'b1;
   logic                        start             = 1'b0;
   logic                        busy;
   logic                        req_action        = fsc_pkg::ACT_LOAD;
   logic [5:0]                  req_slot          = '0;
   logic [63:0]                 req_pattern_text  = '0;
   logic [63:0]                 req_ext_text      = '0;
   logic                        req_ext_present   = 1'b0;
   logic                        req_header_ok     = 1'b0;
   logic [31:0]                 req_header_low    = '0;
   logic [31:0]                 req_header_high   = '0;
   logic                        rsp_valid;
   logic                        rsp_scan;
   logic [fsc_pkg::CAUSE_W-1:0] rsp_cause;
   logic                        csr_we            = 1'b0;
   logic [1:0]                  csr_index         = fsc_pkg::REG_LIST_VALID;
   logic [6:0]                  csr_wdata         = '0;

   file_req_type               file_reqs[$];
   verdict_type                expected_verdicts[$];
   file_req_type               in_flight;
   logic [fsc_pkg::WORD_W-1:0] shadow_table [MAX_PATTERNS];
   logic                       shadow_list_valid = 1'b0;
   logic [6:0]                 shadow_count      = '0;
   int                         gap_left          = 0;
   bit                         calm              = 1'b0;
   int                         mismatches        = 0;
   int                         cycle_count       = 0;

   file_scan_selector #(
      .MAX_PATTERNS(MAX_PATTERNS),
      .MAX_CHARS   (MAX_CHARS)
   ) uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic logic [fsc_pkg::WORD_W-1:0] fold_case(
      input logic [fsc_pkg::WORD_W-1:0] w);
      logic [fsc_pkg::CHAR_W-1:0] c;
      logic [fsc_pkg::WORD_W-1:0] r;
      r = w;
      for (int i = 0; i < fsc_pkg::WORD_CHRS; i++) begin
         c = w[i*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W];
         if (c >= fsc_pkg::CH_LC_A && c <= fsc_pkg::CH_LC_Z) begin
            r[i*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W] = c ^ fsc_pkg::CASE_OFS;
         end
      end
      return r;
   endfunction

   // string ends at the first nul or after MAX_CHARS characters
   function automatic logic [TEXT_W-1:0] clip_text(input logic [fsc_pkg::WORD_W-1:0] w);
      logic [TEXT_W-1:0] r;
      logic              ended;
      r = '0;
      ended = 1'b0;
      for (int i = 0; i < MAX_CHARS; i++) begin
         if (w[i*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W] == fsc_pkg::CH_NUL) begin
            ended = 1'b1;
         end
         if (!ended) begin
            r[i*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W] = w[i*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W];
         end
      end
      return r;
   endfunction

   function automatic logic glob_hits(input logic [TEXT_W-1:0] pat,
                                      input logic [TEXT_W-1:0] ext);
      int                         p;
      int                         e;
      logic [fsc_pkg::CHAR_W-1:0] pc;
      logic [fsc_pkg::CHAR_W-1:0] follow;
      p = 0;
      e = 0;
      while (p < TEXT_CHRS && pat[p*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W] != fsc_pkg::CH_NUL) begin
         pc = pat[p*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W];
         if (pc == fsc_pkg::CH_STAR) begin
            follow = (p + 1 < TEXT_CHRS) ? pat[(p+1)*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W]
                                         : fsc_pkg::CH_NUL;
            // no backtracking: stop at the first literal copy of the next char
            forever begin
               if (e >= TEXT_CHRS ||
                   ext[e*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W] == fsc_pkg::CH_NUL) begin
                  return follow == fsc_pkg::CH_NUL;
               end
               if (ext[e*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W] == follow) begin
                  break;
               end
               e++;
            end
            p += 2;
            e += 1;
         end else if (pc == fsc_pkg::CH_QUEST) begin
            if (e >= TEXT_CHRS ||
                ext[e*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W] == fsc_pkg::CH_NUL) begin
               return 1'b0;
            end
            p++;
            e++;
         end else begin
            if (e >= TEXT_CHRS || ext[e*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W] != pc) begin
               return 1'b0;
            end
            p++;
            e++;
         end
      end
      return e >= TEXT_CHRS || ext[e*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W] == fsc_pkg::CH_NUL;
   endfunction

   task automatic judge_request(input file_req_type r);
      verdict_type       v;
      logic [TEXT_W-1:0] ext;
      logic [15:0]       mark;
      int                n;
      v.scan = 1'b0;
      v.cause = fsc_pkg::CAUSE_NONE;
      mark = r.header_low[15:0];
      if (r.action == fsc_pkg::ACT_LOAD) begin
         shadow_table[r.slot] = fold_case(r.pattern_text);
      end else begin
         if (!shadow_list_valid) begin
            v.scan = 1'b1;
            v.cause = fsc_pkg::CAUSE_INVALID;
         end else if (r.header_ok &&
                      ((r.header_low == fsc_pkg::SIG_STD_FIRST &&
                        r.header_high == fsc_pkg::SIG_STD_SECOND) ||
                       (r.header_low == fsc_pkg::SIG_B1_FIRST &&
                        r.header_high == fsc_pkg::SIG_B1_SECOND) ||
                       (r.header_low == fsc_pkg::SIG_B2_FIRST &&
                        r.header_high == fsc_pkg::SIG_B2_SECOND))) begin
            v.scan = 1'b1;
            v.cause = fsc_pkg::CAUSE_OFFICE;
         end else if (r.header_ok &&
                      (mark == fsc_pkg::MARK_MZ || mark == fsc_pkg::MARK_ZM ||
                       mark == fsc_pkg::MARK_NE || mark == fsc_pkg::MARK_LE ||
                       mark == fsc_pkg::MARK_PE)) begin
            v.scan = 1'b1;
            v.cause = fsc_pkg::CAUSE_EXEC;
         end else if (r.ext_present) begin
            ext = clip_text(fold_case(r.ext_text));
            n = (shadow_count > MAX_PATTERNS) ? MAX_PATTERNS : shadow_count;
            for (int i = 0; i < n; i++) begin
               if (v.cause == fsc_pkg::CAUSE_NONE &&
                   glob_hits(clip_text(shadow_table[i]), ext)) begin
                  v.scan = 1'b1;
                  v.cause = fsc_pkg::CAUSE_EXT;
               end
            end
         end
         expected_verdicts.insert(expected_verdicts.size(), v);
      end
   endtask

   // ------------------------------------------------------------- stimulus

   function automatic logic [fsc_pkg::WORD_W-1:0] pack_text(input string s);
      logic [fsc_pkg::WORD_W-1:0] w;
      w = '0;
      for (int i = 0; i < s.len() && i < fsc_pkg::WORD_CHRS; i++) begin
         w[i*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W] = s[i];
      end
      return w;
   endfunction

   function automatic logic [fsc_pkg::WORD_W-1:0] random_text();
      string                      glyphs;
      logic [fsc_pkg::WORD_W-1:0] w;
      int                         len;
      glyphs = "ABCabc?*";
      w = '0;
      if ($urandom_range(0, 9) == 0) begin
         w = {$urandom, $urandom};
      end else begin
         len = $urandom_range(0, MAX_CHARS);
         for (int i = 0; i < len; i++) begin
            w[i*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W] = glyphs[$urandom_range(0, 7)];
         end
         // junk behind the terminator
         if (len < MAX_CHARS - 1 && $urandom_range(0, 3) == 0) begin
            for (int i = len + 1; i < fsc_pkg::WORD_CHRS; i++) begin
               w[i*fsc_pkg::CHAR_W +: fsc_pkg::CHAR_W] = 8'($urandom);
            end
         end
      end
      return w;
   endfunction

   function automatic file_req_type random_request();
      file_req_type r;
      r.action = ($urandom_range(0, 9) < 3) ? fsc_pkg::ACT_LOAD : fsc_pkg::ACT_QUERY;
      r.slot = 6'($urandom_range(0, MAX_PATTERNS - 1));
      r.pattern_text = random_text();
      r.ext_text = random_text();
      r.ext_present = ($urandom_range(0, 7) != 0);
      r.header_ok = ($urandom_range(0, 4) != 0);
      r.header_low = $urandom;
      r.header_high = $urandom;
      case ($urandom_range(0, 11))
         0: begin
            r.header_low = fsc_pkg::SIG_STD_FIRST;
            r.header_high = fsc_pkg::SIG_STD_SECOND;
         end
         1: begin
            r.header_low = fsc_pkg::SIG_B1_FIRST;
            r.header_high = fsc_pkg::SIG_B1_SECOND;
         end
         2: begin
            r.header_low = fsc_pkg::SIG_B2_FIRST;
            r.header_high = fsc_pkg::SIG_B2_SECOND;
         end
         3: begin
            case ($urandom_range(0, 4))
               0: r.header_low[15:0] = fsc_pkg::MARK_MZ;
               1: r.header_low[15:0] = fsc_pkg::MARK_ZM;
               2: r.header_low[15:0] = fsc_pkg::MARK_NE;
               3: r.header_low[15:0] = fsc_pkg::MARK_LE;
               default: r.header_low[15:0] = fsc_pkg::MARK_PE;
            endcase
         end
         // signature first word with a wrong second word
         4: r.header_low = fsc_pkg::SIG_STD_FIRST;
         default: ;
      endcase
      return r;
   endfunction

   task automatic queue_load(input int slot, input logic [fsc_pkg::WORD_W-1:0] text);
      file_req_type r;
      r = random_request();
      r.action = fsc_pkg::ACT_LOAD;
      r.slot = 6'(slot);
      r.pattern_text = text;
      file_reqs.insert(file_reqs.size(), r);
   endtask

   task automatic queue_query(input logic [fsc_pkg::WORD_W-1:0] ext, input logic present,
                              input logic hdr_ok, input logic [31:0] lo,
                              input logic [31:0] hi);
      file_req_type r;
      r = random_request();
      r.action = fsc_pkg::ACT_QUERY;
      r.ext_text = ext;
      r.ext_present = present;
      r.header_ok = hdr_ok;
      r.header_low = lo;
      r.header_high = hi;
      file_reqs.insert(file_reqs.size(), r);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [6:0] value);
      logic [6:0] data;
      data = value;
      if (index == fsc_pkg::REG_LIST_VALID) begin
         data[6:1] = 6'($urandom);
         shadow_list_valid = data[0];
      end else begin
         shadow_count = data;
      end
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // block idle: every beat taken, every verdict seen, then the search drains
   task automatic settle();
      while (file_reqs.size() != 0 || start || expected_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // list not loaded: even an executable header answers with list invalid
      write_reg(fsc_pkg::REG_LIST_VALID, 7'd0);
      write_reg(fsc_pkg::REG_PATTERN_COUNT, 7'd5);
      queue_query(pack_text("EXE"), 1'b1, 1'b1, {16'h0, fsc_pkg::MARK_MZ}, 32'h0);
      queue_query(pack_text("DOC"), 1'b1, 1'b1, fsc_pkg::SIG_STD_FIRST,
                  fsc_pkg::SIG_STD_SECOND);
      // every slot gets loaded so no search reads an empty entry
      queue_load(0, pack_text("EXE"));
      queue_load(1, pack_text("d?c"));
      queue_load(2, pack_text("X*"));
      queue_load(3, pack_text("*Z"));
      queue_load(4, pack_text("A*C?"));
      queue_load(5, pack_text("*?"));
      queue_load(6, pack_text("ABCDEFGH"));
      queue_load(7, '0);
      for (int s = 8; s < MAX_PATTERNS; s++) begin
         queue_load(s, random_text());
      end
      settle();

      // header checks with an empty search
      write_reg(fsc_pkg::REG_LIST_VALID, 7'd1);
      write_reg(fsc_pkg::REG_PATTERN_COUNT, 7'd0);
      queue_query(pack_text("EXE"), 1'b1, 1'b1, fsc_pkg::SIG_STD_FIRST,
                  fsc_pkg::SIG_STD_SECOND);
      queue_query(pack_text("EXE"), 1'b1, 1'b1, fsc_pkg::SIG_B1_FIRST,
                  fsc_pkg::SIG_B1_SECOND);
      queue_query(pack_text("EXE"), 1'b1, 1'b1, fsc_pkg::SIG_B2_FIRST,
                  fsc_pkg::SIG_B2_SECOND);
      queue_query(pack_text("EXE"), 1'b1, 1'b1, {16'h1234, fsc_pkg::MARK_MZ}, 32'h0);
      queue_query(pack_text("EXE"), 1'b1, 1'b1, {16'hFFFF, fsc_pkg::MARK_ZM}, 32'h0);
      queue_query(pack_text("EXE"), 1'b1, 1'b1, {16'h0000, fsc_pkg::MARK_NE}, 32'h0);
      queue_query(pack_text("EXE"), 1'b1, 1'b1, {16'h8000, fsc_pkg::MARK_LE}, 32'h0);
      queue_query(pack_text("EXE"), 1'b1, 1'b1, {16'h0001, fsc_pkg::MARK_PE}, 32'h0);
      queue_query(pack_text("EXE"), 1'b1, 1'b0, fsc_pkg::SIG_STD_FIRST,
                  fsc_pkg::SIG_STD_SECOND);
      queue_query(pack_text("EXE"), 1'b1, 1'b1, fsc_pkg::SIG_STD_FIRST,
                  fsc_pkg::SIG_B2_FIRST);
      queue_query('1, 1'b1, 1'b1, '1, '1);
      settle();

      // wildcard corners against the first eight slots
      write_reg(fsc_pkg::REG_PATTERN_COUNT, 7'd8);
      queue_query(pack_text("exe"), 1'b1, 1'b1, '0, '0);
      queue_query(pack_text("DOC"), 1'b1, 1'b1, '0, '0);
      queue_query(pack_text("X"), 1'b1, 1'b1, '0, '0);
      queue_query(pack_text("QQZ"), 1'b1, 1'b1, '0, '0);
      queue_query(pack_text("ABBCD"), 1'b1, 1'b1, '0, '0);
      queue_query(pack_text("ACCC"), 1'b1, 1'b1, '0, '0);
      queue_query(pack_text("K?"), 1'b1, 1'b1, '0, '0);
      queue_query(pack_text("abcdefgh"), 1'b1, 1'b1, '0, '0);
      queue_query('0, 1'b1, 1'b1, '0, '0);
      queue_query(pack_text("DOC"), 1'b0, 1'b1, '0, '0);
      queue_query(pack_text("DOC"), 1'b1, 1'b0, {16'h0, fsc_pkg::MARK_MZ}, '0);
      queue_query(pack_text("Q") | (pack_text("EXE") << 16), 1'b1, 1'b1, '0, '0);
      settle();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(fsc_pkg::REG_LIST_VALID, 7'd1);
               write_reg(fsc_pkg::REG_PATTERN_COUNT, 7'd64);
            end
            1: begin
               write_reg(fsc_pkg::REG_LIST_VALID, 7'd1);
               write_reg(fsc_pkg::REG_PATTERN_COUNT, 7'($urandom_range(1, 63)));
            end
            2: begin
               write_reg(fsc_pkg::REG_LIST_VALID, 7'd0);
               write_reg(fsc_pkg::REG_PATTERN_COUNT, 7'd127);
            end
            3: begin
               write_reg(fsc_pkg::REG_LIST_VALID, 7'd1);
               write_reg(fsc_pkg::REG_PATTERN_COUNT, 7'd127);
            end
            4: begin
               write_reg(fsc_pkg::REG_LIST_VALID, 7'd1);
               write_reg(fsc_pkg::REG_PATTERN_COUNT, 7'd1);
            end
            default: begin
               write_reg(fsc_pkg::REG_LIST_VALID, 7'd1);
               write_reg(fsc_pkg::REG_PATTERN_COUNT, 7'($urandom_range(65, 126)));
            end
         endcase
         calm = (ph == 5);
         for (int i = 0; i < PHASE_BEATS; i++) begin
            file_reqs.insert(file_reqs.size(), random_request());
         end
         settle();
      end

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // --------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            judge_request(in_flight);
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (file_reqs.size() != 0) begin
               in_flight = file_reqs.pop_front();
               req_action <= in_flight.action;
               req_slot <= in_flight.slot;
               req_pattern_text <= in_flight.pattern_text;
               req_ext_text <= in_flight.ext_text;
               req_ext_present <= in_flight.ext_present;
               req_header_ok <= in_flight.header_ok;
               req_header_low <= in_flight.header_low;
               req_header_high <= in_flight.header_high;
               start <= 1'b1;
               // pause after this beat is taken
               if (!calm && $urandom_range(0, 3) == 0) begin
                  gap_left = $urandom_range(1, 6);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------- monitor

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_verdicts.size() == 0) begin
            $error("result with nothing expected: scan %0d, cause %0d", rsp_scan, rsp_cause);
            mismatches++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_scan !== want.scan) begin
               $error("scan: expected %0d, actual %0d", want.scan, rsp_scan);
               mismatches++;
            end
            if (rsp_cause !== want.cause) begin
               $error("cause: expected %0d, actual %0d", want.cause, rsp_cause);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
